// ----- sv/lap3_pkg.sv -----
`default_nettype none
package lap3_pkg;

  // Pixel and coordinate widths of the stream.
  localparam int unsigned PixW   = 8;
  localparam int unsigned CoordW = 10;

  // Width of the dimension registers.
  localparam int unsigned DimW = 11;

  // Largest frame the line store supports.
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned AddrW     = $clog2(MaxWidth);

  // One line store word holds the pixel two rows up and the pixel one row up.
  localparam int unsigned LineW = 2 * PixW;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Reset values of the dimension registers.
  localparam logic [DimW-1:0] WidthReset  = DimW'(640);
  localparam logic [DimW-1:0] HeightReset = DimW'(480);

  // Results one pixel can cause, in the order they leave the block.
  localparam int unsigned NumRes = 4;
  typedef logic [NumRes-1:0] res_mask_t;
  localparam int unsigned ResAboveLeft = 0;
  localparam int unsigned ResAboveHere = 1;
  localparam int unsigned ResCurLeft   = 2;
  localparam int unsigned ResCurHere   = 3;

endpackage
`default_nettype wire

// ----- sv/lap3_line_ram.sv -----
`default_nettype none
module lap3_line_ram #(
  parameter int unsigned AddrW = 10,
  parameter int unsigned DataW = 16
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [2**AddrW];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- sv/laplacian_sharpen_3x3.sv -----
`default_nettype none
// 3x3 Laplacian sharpening of an 8-bit greyscale stream in raster order: each
// output is 5*centre minus the four direct neighbours, clamped to 0..255, with
// edge pixels repeated at the frame border. Results trail the input by one row
// and one column and carry their row and column; on the last row the final
// two rows are flushed. A pixel is taken every cycle as long as each pixel
// causes at most one result and the receiver takes every beat; a pixel that
// causes several results (row ends and the last row) stalls the input until
// all have left, since the single output register sends one beat per cycle.
// The two previous rows sit in one 1024-entry line store with a registered
// read, read at the column of the arriving pixel and written back as it leaves
// stage 1, with a forward for back-to-back hits on the same entry (a frame
// one pixel wide). Write image_width and image_height only while the block
// is idle; 0 acts as 1 and values above 1024 act as 1024.
module laplacian_sharpen_3x3 (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration writes.
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [lap3_pkg::DimW-1:0]    cfg_data_i,
  // Pixel input.
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [lap3_pkg::PixW-1:0]    pixel_in_i,
  // Sharpened output.
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [lap3_pkg::PixW-1:0]    pixel_out_o,
  output logic      [lap3_pkg::CoordW-1:0]  out_row_o,
  output logic      [lap3_pkg::CoordW-1:0]  out_col_o,
  output logic                              last_of_run_o,
  output logic                              end_of_frame_o
);

  localparam int unsigned PixW   = lap3_pkg::PixW;
  localparam int unsigned CoordW = lap3_pkg::CoordW;
  localparam int unsigned DimW   = lap3_pkg::DimW;
  localparam int unsigned AddrW  = lap3_pkg::AddrW;
  localparam int unsigned LineW  = lap3_pkg::LineW;
  localparam logic [DimW-1:0] MaxW = DimW'(lap3_pkg::MaxWidth);
  localparam logic [DimW-1:0] MaxH = DimW'(lap3_pkg::MaxHeight);

  // Clamp a dimension register to its usable range.
  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v,
                                              input logic [DimW-1:0] maxv);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Five times the centre minus the neighbours, clamped to a pixel.
  function automatic logic [PixW-1:0] sharpen(input logic [PixW-1:0] ctr,
                                              input logic [PixW-1:0] up,
                                              input logic [PixW-1:0] dn,
                                              input logic [PixW-1:0] lf,
                                              input logic [PixW-1:0] rt);
    logic signed [PixW+3:0] s;
    logic [PixW-1:0] r;
    s = $signed({2'b00, ctr, 2'b00}) + $signed({4'b0000, ctr})
        - $signed({4'b0000, up}) - $signed({4'b0000, dn})
        - $signed({4'b0000, lf}) - $signed({4'b0000, rt});
    if (s[PixW+3]) begin
      r = '0;
    end else if (s > $signed((PixW+4)'(255))) begin
      r = '1;
    end else begin
      r = s[PixW-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [DimW-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lap3_pkg::WidthReset;
      height_q <= lap3_pkg::HeightReset;
    end else if (cfg_we_i) begin
      unique case (lap3_pkg::cfg_reg_e'(cfg_idx_i))
        lap3_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        lap3_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [DimW-1:0] w_eff, h_eff;
  assign w_eff = eff_dim(width_q, MaxW);
  assign h_eff = eff_dim(height_q, MaxH);

  // Handshake and stage control.
  logic accept, s1_go, s2_free, out_free, emit;
  logic s1_v_q;
  lap3_pkg::res_mask_t s2_mask_q, sel, mask_nx, s1_mask;

  // Raster counters and the position flags of the arriving pixel.
  logic [CoordW-1:0] cnt_col_q, cnt_row_q;
  logic end_row, last_row;

  assign end_row  = ({1'b0, cnt_col_q} + DimW'(1)) >= w_eff;
  assign last_row = ({1'b0, cnt_row_q} + DimW'(1)) >= h_eff;
  assign accept   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_col_q <= '0;
      cnt_row_q <= '0;
    end else if (accept) begin
      if (end_row) begin
        cnt_col_q <= '0;
        cnt_row_q <= last_row ? '0 : cnt_row_q + CoordW'(1);
      end else begin
        cnt_col_q <= cnt_col_q + CoordW'(1);
      end
    end
  end

  // Stage 1: pixel waits for its line store word.
  logic [PixW-1:0]   s1_pix_q;
  logic [CoordW-1:0] s1_col_q, s1_row_q;
  logic              s1_end_q, s1_last_q;
  logic              fwd_q;
  logic [LineW-1:0]  fwd_data_q, rd_data, s1_line, wr_data;

  assign s1_go      = s1_v_q && s2_free;
  assign in_ready_o = !s1_v_q || s1_go;
  assign s1_line    = fwd_q ? fwd_data_q : rd_data;
  // The word moves down one row: the previous row becomes two rows up.
  assign wr_data    = {s1_line[PixW-1:0], s1_pix_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      fwd_q  <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_q <= 1'b1;
        fwd_q  <= s1_go && (s1_col_q == cnt_col_q);
      end else if (s1_go) begin
        s1_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q   <= pixel_in_i;
      s1_col_q   <= cnt_col_q;
      s1_row_q   <= cnt_row_q;
      s1_end_q   <= end_row;
      s1_last_q  <= last_row;
      fwd_data_q <= wr_data;
    end
  end

  lap3_line_ram #(
    .AddrW(AddrW),
    .DataW(LineW)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (s1_go),
    .waddr_i(s1_col_q),
    .wdata_i(wr_data),
    .re_i   (accept),
    .raddr_i(cnt_col_q),
    .rdata_o(rd_data)
  );

  // Results this pixel causes.
  always_comb begin
    s1_mask = '0;
    s1_mask[lap3_pkg::ResAboveLeft] = (s1_row_q != '0) && (s1_col_q != '0);
    s1_mask[lap3_pkg::ResAboveHere] = (s1_row_q != '0) && s1_end_q;
    s1_mask[lap3_pkg::ResCurLeft]   = s1_last_q && (s1_col_q != '0);
    s1_mask[lap3_pkg::ResCurHere]   = s1_last_q && s1_end_q;
  end

  // Stage 2: window of three columns by three rows, and pending results.
  logic [PixW-1:0]   win_q [3][3];
  logic [CoordW-1:0] s2_col_q, s2_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (s1_go) begin
      win_q[0]    <= win_q[1];
      win_q[1]    <= win_q[2];
      win_q[2][0] <= s1_line[LineW-1:PixW];
      win_q[2][1] <= s1_line[PixW-1:0];
      win_q[2][2] <= s1_pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_mask_q <= '0;
    end else if (s1_go) begin
      s2_mask_q <= s1_mask;
    end else if (emit) begin
      s2_mask_q <= mask_nx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_col_q <= s1_col_q;
      s2_row_q <= s1_row_q;
    end
  end

  assign out_free = !out_valid_o || out_ready_i;
  assign emit     = (s2_mask_q != '0) && out_free;
  assign sel      = s2_mask_q & (~s2_mask_q + lap3_pkg::NumRes'(1));
  assign mask_nx  = s2_mask_q & ~sel;
  assign s2_free  = (s2_mask_q == '0) || (emit && (mask_nx == '0));

  // Operands of the selected result.
  logic            ccol_hi, k_top;
  logic [1:0]      ci, ki;
  logic            has_up, has_left;
  logic [PixW-1:0] ctr, up, dn, lf, rt;
  logic [PixW-1:0] res_pix;

  always_comb begin
    ccol_hi  = sel[lap3_pkg::ResAboveHere] || sel[lap3_pkg::ResCurHere];
    k_top    = sel[lap3_pkg::ResAboveLeft] || sel[lap3_pkg::ResAboveHere];
    ci       = ccol_hi ? 2'd2 : 2'd1;
    ki       = k_top ? 2'd1 : 2'd2;
    has_up   = k_top ? (s2_row_q > CoordW'(1)) : (s2_row_q != '0);
    has_left = ccol_hi ? (s2_col_q != '0) : (s2_col_q > CoordW'(1));
    ctr      = win_q[ci][ki];
    up       = has_up ? win_q[ci][ki - 2'd1] : ctr;
    dn       = k_top ? win_q[ci][2] : ctr;
    lf       = has_left ? win_q[ci - 2'd1][ki] : ctr;
    rt       = ccol_hi ? ctr : win_q[2][ki];
    res_pix  = sharpen(ctr, up, dn, lf, rt);
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pixel_out_o    <= res_pix;
      out_row_o      <= k_top ? s2_row_q - CoordW'(1) : s2_row_q;
      out_col_o      <= ccol_hi ? s2_col_q : s2_col_q - CoordW'(1);
      last_of_run_o  <= (mask_nx == '0);
      end_of_frame_o <= sel[lap3_pkg::ResCurHere];
    end
  end

endmodule
`default_nettype wire

// ----- sv/lap3_checker.sv -----
`default_nettype none
module lap3_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [lap3_pkg::PixW-1:0]    pixel_out_o,
  input wire logic [lap3_pkg::CoordW-1:0]  out_row_o,
  input wire logic [lap3_pkg::CoordW-1:0]  out_col_o,
  input wire logic                         last_of_run_o,
  input wire logic                         end_of_frame_o
);

  // Reset clears the output, so no beat is offered on the next edge.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid after reset");

  // A stalled beat stays offered with the same contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_out_o)
      && $stable(out_row_o) && $stable(out_col_o) && $stable(last_of_run_o)
      && $stable(end_of_frame_o))
    else $error("stalled output beat changed");

  // The bottom-right pixel is always the final result of its input pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_frame_o |-> last_of_run_o)
    else $error("end of frame without last of run");

  // The results of one pixel leave back to back once the receiver takes them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_run_o |=> out_valid_o)
    else $error("gap inside a run of results");

endmodule

bind laplacian_sharpen_3x3 lap3_checker u_lap3_checker (.*);
`default_nettype wire
